// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W        = 32;
	localparam int REQ_W         = 3;
	localparam int STATUS_W      = 2;
	localparam int FILL_W        = 5;

	localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TRAVERSE   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]         req_type;
		logic signed [DATA_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		logic [STATUS_W-1:0]      status;
		logic                     last_item;
		logic [FILL_W-1:0]        fill_level;
	} rsp_t;

endpackage

// ===== rtl/core/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Single-write, single-read entry store with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int DEPTH  = bdq_pkg::DEPTH_DEFAULT,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ADDR_W-1:0]             waddr,
	input  logic [bdq_pkg::DATA_W-1:0]    wdata,
	input  logic                          re,
	input  logic [ADDR_W-1:0]             raddr,
	output logic [bdq_pkg::DATA_W-1:0]    rdata
);

	logic [bdq_pkg::DATA_W-1:0] mem_q [DEPTH];
	logic [bdq_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bounded_deque_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_unit
// Bounded double-ended queue of signed words kept in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_stall  bdq_pkg::req_t (req_type, push_value)
//  rsp      out  rsp_valid/rsp_stall  bdq_pkg::rsp_t (data_out, status,
//                                     last_item, fill_level)
//
//  Push, error and ignored requests: the result is registered in S_CALC and rsp_valid rises on entry to S_EMIT.
//  Pops: S_CALC, then S_DATA for the registered memory read, then S_EMIT.
//  Traverse: each stored word passes S_CALC, S_DATA and S_EMIT in turn, one
//  memory read and one ring-address add per word through the shared ring adder.
//  Reset clears head and count; the entry store is not cleared.
//  req_stall is high from acceptance until the last result is taken, then
//  low in S_IDLE, where the next request can be taken.
// ----------------------------------------------------------------------------
module bounded_deque_unit #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bdq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bdq_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_DATA,
		S_EMIT
	} state_t;

	state_t                          state_q;
	logic [AW-1:0]                   head_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   idx_q;
	logic [bdq_pkg::REQ_W-1:0]       req_type_q;
	logic [bdq_pkg::DATA_W-1:0]      value_q;
	logic                            rsp_valid_q;
	bdq_pkg::rsp_t                   rsp_q;

	logic [CW-1:0]                   off;
	logic [SW-1:0]                   sum;
	logic [AW-1:0]                   ring_addr;
	logic                            full;
	logic                            empty;
	logic                            mem_we;
	logic                            mem_re;
	logic [bdq_pkg::DATA_W-1:0]      mem_rdata;
	logic [CW-1:0]                   idx_nxt;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign idx_nxt = idx_q + CW'(1);

	always_comb begin
		off = '0;
		if (state_q == S_DATA) begin
			off = CW'(1);
		end else begin
			case (req_type_q)
				bdq_pkg::REQ_PUSH_REAR:  off = count_q;
				bdq_pkg::REQ_PUSH_FRONT: off = CW'(DEPTH - 1);
				bdq_pkg::REQ_POP_FRONT:  off = '0;
				bdq_pkg::REQ_POP_REAR:   off = count_q - CW'(1);
				bdq_pkg::REQ_TRAVERSE:   off = idx_q;
				default:                 off = '0;
			endcase
		end
	end

	always_comb begin
		sum = SW'(head_q) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		ring_addr = AW'(sum);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		if (state_q == S_CALC) begin
			case (req_type_q)
				bdq_pkg::REQ_PUSH_REAR, bdq_pkg::REQ_PUSH_FRONT: mem_we = !full;
				bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_REAR,
				bdq_pkg::REQ_TRAVERSE:                           mem_re = !empty;
				default:                                         mem_re = 1'b0;
			endcase
		end
	end

	bdq_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ring_addr),
		.wdata (value_q),
		.re    (mem_re),
		.raddr (ring_addr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_type_q <= req.req_type;
						value_q    <= req.push_value;
						idx_q      <= '0;
						state_q    <= S_CALC;
					end
				end
				S_CALC: begin
					rsp_q.data_out   <= '0;
					rsp_q.status     <= bdq_pkg::ST_OK;
					rsp_q.last_item  <= 1'b1;
					rsp_q.fill_level <= bdq_pkg::FILL_W'(count_q);
					state_q          <= S_EMIT;
					rsp_valid_q      <= 1'b1;
					case (req_type_q)
						bdq_pkg::REQ_PUSH_REAR, bdq_pkg::REQ_PUSH_FRONT: begin
							if (full) begin
								rsp_q.status <= bdq_pkg::ST_FULL;
							end else begin
								if (req_type_q == bdq_pkg::REQ_PUSH_FRONT) begin
									head_q <= ring_addr;
								end
								count_q          <= count_q + CW'(1);
								rsp_q.fill_level <= bdq_pkg::FILL_W'(count_q + CW'(1));
							end
						end
						bdq_pkg::REQ_POP_FRONT, bdq_pkg::REQ_POP_REAR,
						bdq_pkg::REQ_TRAVERSE: begin
							if (empty) begin
								rsp_q.status <= bdq_pkg::ST_EMPTY;
							end else begin
								state_q     <= S_DATA;
								rsp_valid_q <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				S_DATA: begin
					rsp_q.data_out <= mem_rdata;
					state_q        <= S_EMIT;
					rsp_valid_q    <= 1'b1;
					if (req_type_q == bdq_pkg::REQ_TRAVERSE) begin
						rsp_q.last_item <= (idx_nxt == count_q);
					end else begin
						if (req_type_q == bdq_pkg::REQ_POP_FRONT) begin
							head_q <= ring_addr;
						end
						count_q          <= count_q - CW'(1);
						rsp_q.fill_level <= bdq_pkg::FILL_W'(count_q - CW'(1));
					end
				end
				S_EMIT: begin
					if (!rsp_stall) begin
						rsp_valid_q <= 1'b0;
						if (rsp_q.last_item) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_nxt;
							state_q <= S_CALC;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_busy_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> req_stall)
		else $error("request accepted while a result is pending");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall && rsp.last_item) |=> (!rsp_valid && !req_stall))
		else $error("activity after final result of a transaction");

	a_trav_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last_item) |-> (rsp.status == bdq_pkg::ST_OK))
		else $error("non-final result with error status");
`endif

endmodule
